// ----- hdl/csps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csps_pkg
// Shared types, widths, edge codes and helpers for the cube surface particle
// step datapath.
// ----------------------------------------------------------------------------
package csps_pkg;

    // field widths of the particle record
    localparam int W_POS  = 14;
    localparam int W_VEL  = 14;
    localparam int W_ACC  = 11;
    localparam int W_EDGE = 4;
    localparam int W_AGE  = 9;
    localparam int W_PIX  = 6;
    localparam int W_LIM  = 9;

    // internal arithmetic width, covers every parameter setting in range
    localparam int W_CALC = 24;

    // configuration port
    localparam int W_PADDR = 3;
    localparam int W_PDATA = 32;
    localparam logic [W_PADDR-3:0] REG_LIFETIME_LIMIT = 1'b0;

    // parameter defaults
    localparam int CUBE_MAX_INDEX_DEF = 63;
    localparam int FRAC_BITS_DEF      = 8;

    localparam logic [W_LIM-1:0] LIMIT_RESET = 9'd260;
    localparam logic [W_AGE-1:0] AGE_MAX     = 9'd511;

    localparam logic signed [W_CALC-1:0] VEL_MIN = -24'sd8192;
    localparam logic signed [W_CALC-1:0] VEL_MAX = 24'sd8191;

    typedef logic        [W_POS-1:0]  t_pos;
    typedef logic signed [W_VEL-1:0]  t_vel;
    typedef logic signed [W_ACC-1:0]  t_acc;
    typedef logic signed [W_CALC-1:0] t_calc;

    // edge codes, numbered in test priority order
    typedef enum logic [W_EDGE-1:0] {
        EDGE_NONE  = 4'd0,
        EDGE_XM_Y0 = 4'd1,
        EDGE_XM_YM = 4'd2,
        EDGE_X0_YM = 4'd3,
        EDGE_X0_Y0 = 4'd4,
        EDGE_Y0_Z0 = 4'd5,
        EDGE_XM_Z0 = 4'd6,
        EDGE_YM_Z0 = 4'd7,
        EDGE_X0_Z0 = 4'd8,
        EDGE_Y0_ZM = 4'd9,
        EDGE_XM_ZM = 4'd10,
        EDGE_YM_ZM = 4'd11,
        EDGE_X0_ZM = 4'd12
    } t_edge;

    // clip a wide signed value to the velocity range
    function automatic t_vel sat_vel(input t_calc v);
        t_calc r;
        if (v < VEL_MIN) begin
            r = VEL_MIN;
        end else if (v > VEL_MAX) begin
            r = VEL_MAX;
        end else begin
            r = v;
        end
        return W_VEL'(r);
    endfunction

endpackage

// ----- hdl/csps_face_accel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csps_face_accel
// Finds the face from the rounded input position and adds the acceleration
// to the two velocity axes tangent to it, with saturation.
// ----------------------------------------------------------------------------
module csps_face_accel #(
    parameter int CUBE_MAX_INDEX = csps_pkg::CUBE_MAX_INDEX_DEF,
    parameter int FRAC_BITS      = csps_pkg::FRAC_BITS_DEF
) (
    input  csps_pkg::t_pos i_pos [3],
    input  csps_pkg::t_vel i_vel [3],
    input  csps_pkg::t_acc i_acc [3],
    output csps_pkg::t_vel o_vel [3]
);
    import csps_pkg::*;

    localparam t_calc HALF = t_calc'(1) << (FRAC_BITS - 1);
    localparam t_calc MAXI = t_calc'(CUBE_MAX_INDEX);

    t_calc pix    [3];
    logic  on_face[3];
    t_vel  sum    [3];

    // rounded pixel, face test and saturated sum per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pix[i]     = (t_calc'({1'b0, i_pos[i]}) + HALF) >>> FRAC_BITS;
            on_face[i] = (pix[i] == '0) || (pix[i] == MAXI);
            sum[i]     = sat_vel(t_calc'(i_vel[i]) + t_calc'(i_acc[i]));
        end
    end

    // x faces first, then y, then z
    always_comb begin
        o_vel = i_vel;
        priority if (on_face[0]) begin
            o_vel[1] = sum[1];
            o_vel[2] = sum[2];
        end else if (on_face[1]) begin
            o_vel[0] = sum[0];
            o_vel[2] = sum[2];
        end else if (on_face[2]) begin
            o_vel[0] = sum[0];
            o_vel[1] = sum[1];
        end else begin
            o_vel = i_vel;
        end
    end

endmodule

// ----- hdl/csps_move_edge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csps_move_edge
// Moves the particle, clamps it to the cube, detects the edge reached and on
// a new edge swaps velocity axes, snaps to the pixel and reflects outward
// components.
// ----------------------------------------------------------------------------
module csps_move_edge #(
    parameter int CUBE_MAX_INDEX = csps_pkg::CUBE_MAX_INDEX_DEF,
    parameter int FRAC_BITS      = csps_pkg::FRAC_BITS_DEF
) (
    input  csps_pkg::t_pos                  i_pos [3],
    input  csps_pkg::t_vel                  i_vel [3],
    input  logic [csps_pkg::W_EDGE-1:0]     i_prev_edge,
    output csps_pkg::t_pos                  o_pos [3],
    output csps_pkg::t_vel                  o_vel [3],
    output logic [csps_pkg::W_PIX-1:0]      o_pix [3],
    output csps_pkg::t_edge                 o_edge
);
    import csps_pkg::*;

    localparam t_calc HALF    = t_calc'(1) << (FRAC_BITS - 1);
    localparam t_calc MAXI    = t_calc'(CUBE_MAX_INDEX);
    localparam t_calc MAX_POS = t_calc'(CUBE_MAX_INDEX) << FRAC_BITS;

    t_calc mv   [3];
    t_calc pix  [3];
    logic  lo   [3];
    logic  hi   [3];
    t_vel  sw   [3];
    logic  new_edge;

    // move, clamp and round
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mv[i] = t_calc'({1'b0, i_pos[i]}) + t_calc'(i_vel[i]);
            if (mv[i] < 0) begin
                mv[i] = '0;
            end else if (mv[i] > MAX_POS) begin
                mv[i] = MAX_POS;
            end
            pix[i] = (mv[i] + HALF) >>> FRAC_BITS;
            lo[i]  = (pix[i] == '0);
            hi[i]  = (pix[i] == MAXI);
        end
    end

    // edge code in priority order
    always_comb begin
        priority if (hi[0] && lo[1]) o_edge = EDGE_XM_Y0;
        else if (hi[0] && hi[1])     o_edge = EDGE_XM_YM;
        else if (lo[0] && hi[1])     o_edge = EDGE_X0_YM;
        else if (lo[0] && lo[1])     o_edge = EDGE_X0_Y0;
        else if (lo[1] && lo[2])     o_edge = EDGE_Y0_Z0;
        else if (hi[0] && lo[2])     o_edge = EDGE_XM_Z0;
        else if (hi[1] && lo[2])     o_edge = EDGE_YM_Z0;
        else if (lo[0] && lo[2])     o_edge = EDGE_X0_Z0;
        else if (lo[1] && hi[2])     o_edge = EDGE_Y0_ZM;
        else if (hi[0] && hi[2])     o_edge = EDGE_XM_ZM;
        else if (hi[1] && hi[2])     o_edge = EDGE_YM_ZM;
        else if (lo[0] && hi[2])     o_edge = EDGE_X0_ZM;
        else                         o_edge = EDGE_NONE;
    end

    assign new_edge = (o_edge != EDGE_NONE) && (W_EDGE'(o_edge) != i_prev_edge);

    // axis swap picked by the edge family
    always_comb begin
        sw = i_vel;
        unique case (o_edge)
            EDGE_XM_Y0, EDGE_XM_YM, EDGE_X0_YM, EDGE_X0_Y0: begin
                sw[0] = i_vel[1];
                sw[1] = i_vel[0];
            end
            EDGE_Y0_Z0, EDGE_YM_Z0, EDGE_Y0_ZM, EDGE_YM_ZM: begin
                sw[1] = i_vel[2];
                sw[2] = i_vel[1];
            end
            EDGE_XM_Z0, EDGE_X0_Z0, EDGE_XM_ZM, EDGE_X0_ZM: begin
                sw[0] = i_vel[2];
                sw[2] = i_vel[0];
            end
            default: begin
                sw = i_vel;
            end
        endcase
    end

    // snap and reflect on a newly reached edge
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_pix[i] = W_PIX'(pix[i]);
            if (new_edge) begin
                o_pos[i] = W_POS'(pix[i] <<< FRAC_BITS);
                if ((lo[i] && sw[i] < 0) || (hi[i] && sw[i] > 0)) begin
                    o_vel[i] = sat_vel(-t_calc'(sw[i]));
                end else begin
                    o_vel[i] = sw[i];
                end
            end else begin
                o_pos[i] = W_POS'(mv[i]);
                o_vel[i] = i_vel[i];
            end
        end
    end

endmodule

// ----- hdl/cube_surface_particle_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_surface_particle_step
// Advances one particle on the surface of an LED cube by one step: face
// acceleration, move and clamp, edge handling, pixel and lifetime flag.
//
//   channel   handshake                      payload
//   input     start / busy (busy held low)   i_pos_*, i_vel_*, i_acc_*,
//                                            i_prev_edge, i_age
//   result    o_done strobe, one cycle       o_new_*, o_pixel_*, o_expired
//   config    APB psel/penable/pwrite        paddr, pwdata, prdata
//
// One item per cycle. The path is an input register, then the face, move
// and edge logic into the result register.
// Synchronous reset clears the valid flags and sets lifetime_limit to 260.
// The receiver takes every result beat in the cycle it is shown.
// ----------------------------------------------------------------------------
module cube_surface_particle_step #(
    parameter int CUBE_MAX_INDEX = csps_pkg::CUBE_MAX_INDEX_DEF,
    parameter int FRAC_BITS      = csps_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  csps_pkg::t_pos                    i_pos_x,
    input  csps_pkg::t_pos                    i_pos_y,
    input  csps_pkg::t_pos                    i_pos_z,
    input  csps_pkg::t_vel                    i_vel_x,
    input  csps_pkg::t_vel                    i_vel_y,
    input  csps_pkg::t_vel                    i_vel_z,
    input  csps_pkg::t_acc                    i_acc_x,
    input  csps_pkg::t_acc                    i_acc_y,
    input  csps_pkg::t_acc                    i_acc_z,
    input  logic [csps_pkg::W_EDGE-1:0]       i_prev_edge,
    input  logic [csps_pkg::W_AGE-1:0]        i_age,
    // result channel
    output logic                              o_done,
    output csps_pkg::t_pos                    o_new_pos_x,
    output csps_pkg::t_pos                    o_new_pos_y,
    output csps_pkg::t_pos                    o_new_pos_z,
    output csps_pkg::t_vel                    o_new_vel_x,
    output csps_pkg::t_vel                    o_new_vel_y,
    output csps_pkg::t_vel                    o_new_vel_z,
    output logic [csps_pkg::W_EDGE-1:0]       o_new_edge,
    output logic [csps_pkg::W_AGE-1:0]        o_new_age,
    output logic [csps_pkg::W_PIX-1:0]        o_pixel_x,
    output logic [csps_pkg::W_PIX-1:0]        o_pixel_y,
    output logic [csps_pkg::W_PIX-1:0]        o_pixel_z,
    output logic                              o_expired,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csps_pkg::W_PADDR-1:0]      paddr,
    input  logic [csps_pkg::W_PDATA-1:0]      pwdata,
    output logic [csps_pkg::W_PDATA-1:0]      prdata,
    output logic                              pready
);
    import csps_pkg::*;

    logic [W_LIM-1:0] r_lifetime_limit;
    logic             cfg_wr;

    // input register
    logic             r_in_valid;
    t_pos             r_pos [3];
    t_vel             r_vel [3];
    t_acc             r_acc [3];
    logic [W_EDGE-1:0] r_prev_edge;
    logic [W_AGE-1:0] r_age;

    // datapath
    t_vel             acc_vel [3];
    t_pos             mv_pos  [3];
    t_vel             mv_vel  [3];
    logic [W_PIX-1:0] mv_pix  [3];
    t_edge            mv_edge;
    logic [W_AGE-1:0] n_age;
    logic             n_expired;

    // result register
    logic             r_done;
    t_pos             r_out_pos [3];
    t_vel             r_out_vel [3];
    logic [W_PIX-1:0] r_out_pix [3];
    logic [W_EDGE-1:0] r_out_edge;
    logic [W_AGE-1:0] r_out_age;
    logic             r_out_expired;

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime_limit <= LIMIT_RESET;
        end else if (cfg_wr && paddr[W_PADDR-1:2] == REG_LIFETIME_LIMIT) begin
            r_lifetime_limit <= pwdata[W_LIM-1:0];
        end
    end

    always_comb begin
        if (paddr[W_PADDR-1:2] == REG_LIFETIME_LIMIT) begin
            prdata = W_PDATA'(r_lifetime_limit);
        end else begin
            prdata = '0;
        end
    end

    // the datapath takes a beat every cycle
    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_pos       <= '{i_pos_x, i_pos_y, i_pos_z};
            r_vel       <= '{i_vel_x, i_vel_y, i_vel_z};
            r_acc       <= '{i_acc_x, i_acc_y, i_acc_z};
            r_prev_edge <= i_prev_edge;
            r_age       <= i_age;
        end
    end

    csps_face_accel #(
        .CUBE_MAX_INDEX (CUBE_MAX_INDEX),
        .FRAC_BITS      (FRAC_BITS)
    ) u_face_accel (
        .i_pos (r_pos),
        .i_vel (r_vel),
        .i_acc (r_acc),
        .o_vel (acc_vel)
    );

    csps_move_edge #(
        .CUBE_MAX_INDEX (CUBE_MAX_INDEX),
        .FRAC_BITS      (FRAC_BITS)
    ) u_move_edge (
        .i_pos       (r_pos),
        .i_vel       (acc_vel),
        .i_prev_edge (r_prev_edge),
        .o_pos       (mv_pos),
        .o_vel       (mv_vel),
        .o_pix       (mv_pix),
        .o_edge      (mv_edge)
    );

    // age and lifetime
    assign n_age     = (r_age < AGE_MAX) ? r_age + 1'b1 : AGE_MAX;
    assign n_expired = (r_age > r_lifetime_limit);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_pos     <= mv_pos;
            r_out_vel     <= mv_vel;
            r_out_pix     <= mv_pix;
            r_out_edge    <= W_EDGE'(mv_edge);
            r_out_age     <= n_age;
            r_out_expired <= n_expired;
        end
    end

    assign o_done      = r_done;
    assign o_new_pos_x = r_out_pos[0];
    assign o_new_pos_y = r_out_pos[1];
    assign o_new_pos_z = r_out_pos[2];
    assign o_new_vel_x = r_out_vel[0];
    assign o_new_vel_y = r_out_vel[1];
    assign o_new_vel_z = r_out_vel[2];
    assign o_new_edge  = r_out_edge;
    assign o_new_age   = r_out_age;
    assign o_pixel_x   = r_out_pix[0];
    assign o_pixel_y   = r_out_pix[1];
    assign o_pixel_z   = r_out_pix[2];
    assign o_expired   = r_out_expired;

`ifndef SYNTH
    // every accepted beat shows up as a result on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted beat produced no result");

    // no result without an accepted beat
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_in_valid))
        else $error("result strobe without a beat");

    // saturating age increment never wraps to zero
    a_age_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_new_age != '0))
        else $error("new age wrapped");
`endif

endmodule

// ----- verif/tb_cube_surface_particle_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cube_surface_particle_step
// Self-checking bench for the cube surface particle step. A behavioral
// predictor in the scoreboard class works out each step's record from the
// accepted command beat. Every o_done beat is compared field by field. The
// stimulus opens with corners, edges, saturation and off-cube cases. Then come
// random particle trajectories fed back step by step, fresh surface spawns and
// raw noise, under several lifetime limits and with random idle gaps.
// ----------------------------------------------------------------------------
module tb_cube_surface_particle_step;

    import csps_pkg::*;

    localparam int CMAX    = CUBE_MAX_INDEX_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int POS_MAX = CMAX << FB;
    localparam int REG_LIMIT    = int'(REG_LIFETIME_LIMIT);
    localparam int REG_UNMAPPED = 1;    // first index past the register list
    localparam int N_PHASES     = 8;
    localparam int PHASE_STEPS  = 240;

    // one particle record as it enters the block; index 0 is x
    typedef struct packed {
        logic [2:0][W_POS-1:0] pos;
        logic [2:0][W_VEL-1:0] vel;
        logic [2:0][W_ACC-1:0] acc;
        logic [W_EDGE-1:0]     prev_edge;
        logic [W_AGE-1:0]      age;
    } particle_in_t;

    // one step result
    typedef struct packed {
        logic [2:0][W_POS-1:0] pos;
        logic [2:0][W_VEL-1:0] vel;
        logic [W_EDGE-1:0]     edge_id;
        logic [W_AGE-1:0]      age;
        logic [2:0][W_PIX-1:0] pix;
        logic                  expired;
    } particle_out_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts each step and checks the results in order
    // ------------------------------------------------------------------------
    class particle_scoreboard;
        particle_out_t    pending_q[$];
        logic [W_LIM-1:0] limit;
        int errors;
        int accepted;
        int checked;
        int edge_hits;
        int expired_hits;

        function new();
            limit = LIMIT_RESET;
        endfunction

        function void set_reg(int idx, logic [31:0] value);
            if (idx == REG_LIMIT) begin
                limit = value[W_LIM-1:0];
            end
        endfunction

        function int clip_velocity(int v);
            if (v < int'(VEL_MIN)) begin
                return int'(VEL_MIN);
            end else if (v > int'(VEL_MAX)) begin
                return int'(VEL_MAX);
            end
            return v;
        endfunction

        function particle_out_t step_particle(particle_in_t p);
            int pos[3];
            int vel[3];
            int acc[3];
            int pix[3];
            int tmp;
            int a;
            int b;
            t_edge e;
            particle_out_t r;
            for (int i = 0; i < 3; i++) begin
                pos[i] = int'(p.pos[i]);
                vel[i] = int'($signed(p.vel[i]));
                acc[i] = int'($signed(p.acc[i]));
                pix[i] = (pos[i] + (1 << (FB - 1))) >> FB;
            end
            // face from the rounded input position, tangent axes accelerate
            if (pix[0] == 0 || pix[0] == CMAX) begin
                vel[1] = clip_velocity(vel[1] + acc[1]);
                vel[2] = clip_velocity(vel[2] + acc[2]);
            end else if (pix[1] == 0 || pix[1] == CMAX) begin
                vel[0] = clip_velocity(vel[0] + acc[0]);
                vel[2] = clip_velocity(vel[2] + acc[2]);
            end else if (pix[2] == 0 || pix[2] == CMAX) begin
                vel[0] = clip_velocity(vel[0] + acc[0]);
                vel[1] = clip_velocity(vel[1] + acc[1]);
            end
            // move and clamp
            for (int i = 0; i < 3; i++) begin
                pos[i] = pos[i] + vel[i];
                if (pos[i] < 0) pos[i] = 0;
                if (pos[i] > POS_MAX) pos[i] = POS_MAX;
                pix[i] = (pos[i] + (1 << (FB - 1))) >> FB;
            end
            // edge lookup, first match wins
            if      (pix[0] == CMAX && pix[1] == 0)    e = EDGE_XM_Y0;
            else if (pix[0] == CMAX && pix[1] == CMAX) e = EDGE_XM_YM;
            else if (pix[0] == 0    && pix[1] == CMAX) e = EDGE_X0_YM;
            else if (pix[0] == 0    && pix[1] == 0)    e = EDGE_X0_Y0;
            else if (pix[1] == 0    && pix[2] == 0)    e = EDGE_Y0_Z0;
            else if (pix[0] == CMAX && pix[2] == 0)    e = EDGE_XM_Z0;
            else if (pix[1] == CMAX && pix[2] == 0)    e = EDGE_YM_Z0;
            else if (pix[0] == 0    && pix[2] == 0)    e = EDGE_X0_Z0;
            else if (pix[1] == 0    && pix[2] == CMAX) e = EDGE_Y0_ZM;
            else if (pix[0] == CMAX && pix[2] == CMAX) e = EDGE_XM_ZM;
            else if (pix[1] == CMAX && pix[2] == CMAX) e = EDGE_YM_ZM;
            else if (pix[0] == 0    && pix[2] == CMAX) e = EDGE_X0_ZM;
            else                                       e = EDGE_NONE;
            // new edge: swap axes, snap to the pixel, turn outward motion back
            if (e != EDGE_NONE && e != p.prev_edge) begin
                case (e)
                    EDGE_XM_Y0, EDGE_XM_YM, EDGE_X0_YM, EDGE_X0_Y0: begin
                        a = 0;
                        b = 1;
                    end
                    EDGE_Y0_Z0, EDGE_YM_Z0, EDGE_Y0_ZM, EDGE_YM_ZM: begin
                        a = 1;
                        b = 2;
                    end
                    default: begin
                        a = 0;
                        b = 2;
                    end
                endcase
                tmp    = vel[a];
                vel[a] = vel[b];
                vel[b] = tmp;
                for (int i = 0; i < 3; i++) begin
                    pos[i] = pix[i] << FB;
                    if ((pix[i] == 0 && vel[i] < 0) || (pix[i] == CMAX && vel[i] > 0)) begin
                        vel[i] = clip_velocity(-vel[i]);
                    end
                end
            end
            for (int i = 0; i < 3; i++) begin
                r.pos[i] = pos[i][W_POS-1:0];
                r.vel[i] = vel[i][W_VEL-1:0];
                r.pix[i] = pix[i][W_PIX-1:0];
            end
            r.edge_id = e;
            r.age     = (p.age < AGE_MAX) ? p.age + 1'b1 : AGE_MAX;
            r.expired = (p.age > limit);
            return r;
        endfunction

        // an accepted command beat
        function void note_input(particle_in_t p);
            particle_out_t r;
            r = step_particle(p);
            pending_q.insert(pending_q.size(), r);
            accepted++;
            if (r.edge_id != EDGE_NONE) edge_hits++;
            if (r.expired) expired_hits++;
        endfunction

        function void check_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        // a result beat on o_done
        function void check_result(particle_out_t act);
            particle_out_t e;
            string axis[3];
            axis = '{"x", "y", "z"};
            if (pending_q.size() == 0) begin
                $error("result beat with no step outstanding");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            for (int i = 0; i < 3; i++) begin
                check_field({"new_pos_", axis[i]}, int'(e.pos[i]), int'(act.pos[i]));
                check_field({"new_vel_", axis[i]}, int'($signed(e.vel[i])),
                            int'($signed(act.vel[i])));
                check_field({"pixel_", axis[i]}, int'(e.pix[i]), int'(act.pix[i]));
            end
            check_field("new_edge", int'(e.edge_id), int'(act.edge_id));
            check_field("new_age", int'(e.age), int'(act.age));
            check_field("expired", int'(e.expired), int'(act.expired));
            checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and DUT
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start;
    logic busy;
    t_pos i_pos_x, i_pos_y, i_pos_z;
    t_vel i_vel_x, i_vel_y, i_vel_z;
    t_acc i_acc_x, i_acc_y, i_acc_z;
    logic [W_EDGE-1:0] i_prev_edge;
    logic [W_AGE-1:0]  i_age;
    logic o_done;
    t_pos o_new_pos_x, o_new_pos_y, o_new_pos_z;
    t_vel o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic [W_EDGE-1:0] o_new_edge;
    logic [W_AGE-1:0]  o_new_age;
    logic [W_PIX-1:0]  o_pixel_x, o_pixel_y, o_pixel_z;
    logic o_expired;
    logic psel, penable, pwrite;
    logic [W_PADDR-1:0] paddr;
    logic [W_PDATA-1:0] pwdata;
    logic [W_PDATA-1:0] prdata;
    logic pready;

    particle_scoreboard sb = new();
    particle_out_t      seen;

    cube_surface_particle_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_vel_z     (i_vel_z),
        .i_acc_x     (i_acc_x),
        .i_acc_y     (i_acc_y),
        .i_acc_z     (i_acc_z),
        .i_prev_edge (i_prev_edge),
        .i_age       (i_age),
        .o_done      (o_done),
        .o_new_pos_x (o_new_pos_x),
        .o_new_pos_y (o_new_pos_y),
        .o_new_pos_z (o_new_pos_z),
        .o_new_vel_x (o_new_vel_x),
        .o_new_vel_y (o_new_vel_y),
        .o_new_vel_z (o_new_vel_z),
        .o_new_edge  (o_new_edge),
        .o_new_age   (o_new_age),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_pixel_z   (o_pixel_z),
        .o_expired   (o_expired),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen.pos     = {o_new_pos_z, o_new_pos_y, o_new_pos_x};
            seen.vel     = {o_new_vel_z, o_new_vel_y, o_new_vel_x};
            seen.pix     = {o_pixel_z, o_pixel_y, o_pixel_x};
            seen.edge_id = o_new_edge;
            seen.age     = o_new_age;
            seen.expired = o_expired;
            sb.check_result(seen);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic particle_in_t mk_particle(input int x, y, z, vx, vy, vz,
                                                 input int ax, ay, az, pe, ag);
        particle_in_t p;
        p.pos[0]    = W_POS'(x);
        p.pos[1]    = W_POS'(y);
        p.pos[2]    = W_POS'(z);
        p.vel[0]    = W_VEL'(vx);
        p.vel[1]    = W_VEL'(vy);
        p.vel[2]    = W_VEL'(vz);
        p.acc[0]    = W_ACC'(ax);
        p.acc[1]    = W_ACC'(ay);
        p.acc[2]    = W_ACC'(az);
        p.prev_edge = W_EDGE'(pe);
        p.age       = W_AGE'(ag);
        return p;
    endfunction

    // mostly slow particles, some fast, a few at the rails
    function automatic logic [W_VEL-1:0] rand_vel();
        int r;
        r = $urandom_range(99);
        if (r < 50) return W_VEL'(int'($urandom_range(800)) - 400);
        if (r < 85) return W_VEL'(int'($urandom_range(4095)) - 2048);
        if (r < 95) return W_VEL'(int'($urandom_range(16383)) - 8192);
        return $urandom_range(1) ? W_VEL'(8191) : W_VEL'(-8192);
    endfunction

    function automatic logic [W_ACC-1:0] rand_acc();
        int r;
        r = $urandom_range(99);
        if (r < 70) return W_ACC'(int'($urandom_range(128)) - 64);
        if (r < 90) return W_ACC'(int'($urandom_range(2047)) - 1024);
        return $urandom_range(1) ? W_ACC'(1023) : W_ACC'(-1024);
    endfunction

    // fresh particle on a random face, often close to an edge
    function automatic particle_in_t spawn_particle();
        particle_in_t p;
        int f;
        int px;
        int q;
        int r;
        f = $urandom_range(2);
        for (int i = 0; i < 3; i++) begin
            if (i == f) begin
                px = $urandom_range(1) ? CMAX : 0;
            end else if ($urandom_range(99) < 40) begin
                px = $urandom_range(1) ? int'($urandom_range(2)) : CMAX - int'($urandom_range(2));
            end else begin
                px = $urandom_range(CMAX);
            end
            q = (px << FB) + int'($urandom_range(255)) - 128;
            if (q < 0) q = 0;
            if (q > POS_MAX) q = POS_MAX;
            p.pos[i] = W_POS'(q);
            p.vel[i] = rand_vel();
            p.acc[i] = rand_acc();
        end
        r = $urandom_range(99);
        if (r < 70)      p.prev_edge = EDGE_NONE;
        else if (r < 90) p.prev_edge = W_EDGE'($urandom_range(12, 1));
        else             p.prev_edge = W_EDGE'($urandom_range(15));
        p.age = W_AGE'($urandom_range(511));
        return p;
    endfunction

    function automatic int pick_gap(bit gappy);
        int r;
        if (!gappy) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // one command beat, after an optional idle gap
    task automatic send_step(input particle_in_t p, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_pos_x     <= p.pos[0];
        i_pos_y     <= p.pos[1];
        i_pos_z     <= p.pos[2];
        i_vel_x     <= p.vel[0];
        i_vel_y     <= p.vel[1];
        i_vel_z     <= p.vel[2];
        i_acc_x     <= p.acc[0];
        i_acc_y     <= p.acc[1];
        i_acc_z     <= p.acc[2];
        i_prev_edge <= p.prev_edge;
        i_age       <= p.age;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_input(p);
    endtask

    // stop issuing and wait for every outstanding result, then the latency
    task automatic drain_steps();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= W_PADDR'(idx * 4);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr) sb.set_reg(idx, wdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        particle_in_t  rec;
        particle_in_t  traj;
        particle_out_t nxt;
        logic [159:0]  noise_bits;
        logic [31:0]   rd;
        int  limits[N_PHASES];
        int  c[3];
        int  v[3];
        int  r;
        bit  have_traj;
        bit  gappy;

        start       = 1'b0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_pos_z     = '0;
        i_vel_x     = '0;
        i_vel_y     = '0;
        i_vel_z     = '0;
        i_acc_x     = '0;
        i_acc_y     = '0;
        i_acc_z     = '0;
        i_prev_edge = '0;
        i_age       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the limit
        apb_xfer(1'b0, REG_LIMIT, '0, rd);
        sb.check_field("lifetime_limit", int'(sb.limit), int'(rd[W_LIM-1:0]));

        // directed: corners, rails, saturation, off-cube, repeat edge, ages
        send_step(mk_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, EDGE_NONE, 0), 0);
        send_step(mk_particle(POS_MAX, POS_MAX, POS_MAX, 8191, 8191, 8191,
                              1023, 1023, 1023, EDGE_NONE, 260), 0);
        send_step(mk_particle(0, 30 << FB, 10 << FB, -8192, -8192, -8192,
                              -1024, -1024, -1024, EDGE_NONE, 261), 0);
        // slam into the x=0,z=0 edge; swapped -8192 reflects to +8191
        send_step(mk_particle(0, 30 << FB, 10 << FB, 0, 0, -8192, 0, 0, 0,
                              EDGE_NONE, 511), 0);
        // sitting on the same edge as last step
        send_step(mk_particle(POS_MAX, 0, 30 << FB, 0, 0, 0, 0, 0, 0, EDGE_XM_Y0, 510), 0);
        // previous edge code past the table
        send_step(mk_particle(POS_MAX, 0, 30 << FB, 200, -200, 40, 0, 0, 0, 13, 0), 1);
        send_step(mk_particle(POS_MAX, 0, 30 << FB, 200, -200, 40, 0, 0, 0, 15, 1), 0);
        // rounded input off the cube: no face, no acceleration
        send_step(mk_particle(16383, 16300, 8000, 100, -100, 50, 1023, 1023, 1023,
                              EDGE_NONE, 0), 0);
        // exact half-pixel positions round up
        send_step(mk_particle(128, (30 << FB) + 128, POS_MAX - 128, 0, 0, 0,
                              5, 5, 5, EDGE_NONE, 100), 2);
        // land on each edge of the cube with outward motion
        for (int k = 1; k <= 12; k++) begin
            case (t_edge'(k))
                EDGE_XM_Y0: c = '{CMAX, 0, 30};
                EDGE_XM_YM: c = '{CMAX, CMAX, 30};
                EDGE_X0_YM: c = '{0, CMAX, 30};
                EDGE_X0_Y0: c = '{0, 0, 30};
                EDGE_Y0_Z0: c = '{30, 0, 0};
                EDGE_XM_Z0: c = '{CMAX, 30, 0};
                EDGE_YM_Z0: c = '{30, CMAX, 0};
                EDGE_X0_Z0: c = '{0, 30, 0};
                EDGE_Y0_ZM: c = '{30, 0, CMAX};
                EDGE_XM_ZM: c = '{CMAX, 30, CMAX};
                EDGE_YM_ZM: c = '{30, CMAX, CMAX};
                default:    c = '{0, 30, CMAX};
            endcase
            for (int i = 0; i < 3; i++) begin
                v[i] = (c[i] == 0) ? -100 : ((c[i] == CMAX) ? 100 : 50);
            end
            send_step(mk_particle(c[0] << FB, c[1] << FB, c[2] << FB, v[0], v[1], v[2],
                                  3, -3, 7, EDGE_NONE, k), k % 3);
        end
        drain_steps();

        // a write past the register list must leave the limit alone
        apb_xfer(1'b1, REG_UNMAPPED, $urandom, rd);
        apb_xfer(1'b0, REG_LIMIT, '0, rd);
        sb.check_field("lifetime_limit", int'(sb.limit), int'(rd[W_LIM-1:0]));

        // random phases, each under its own lifetime limit
        limits = '{0, 511, 1, 510, int'($urandom_range(511)), int'($urandom_range(511)),
                   260, int'($urandom_range(511))};
        have_traj = 1'b0;
        gappy     = 1'b0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            apb_xfer(1'b1, REG_LIMIT, 32'(limits[ph]), rd);
            apb_xfer(1'b0, REG_LIMIT, '0, rd);
            sb.check_field("lifetime_limit", int'(sb.limit), int'(rd[W_LIM-1:0]));
            for (int n = 0; n < PHASE_STEPS; n++) begin
                if (n % 60 == 0) gappy = ($urandom_range(2) != 0);
                r = $urandom_range(99);
                if (r < 10) begin
                    // raw noise over every field bit
                    noise_bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
                    rec = noise_bits[$bits(particle_in_t)-1:0];
                end else if (r < 65 && have_traj && $urandom_range(99) >= 4) begin
                    // follow the particle one more step
                    nxt            = sb.step_particle(traj);
                    rec.pos        = nxt.pos;
                    rec.vel        = nxt.vel;
                    rec.prev_edge  = nxt.edge_id;
                    rec.age        = nxt.age;
                    rec.acc[0]     = rand_acc();
                    rec.acc[1]     = rand_acc();
                    rec.acc[2]     = rand_acc();
                    traj           = rec;
                end else begin
                    rec       = spawn_particle();
                    traj      = rec;
                    have_traj = 1'b1;
                end
                send_step(rec, pick_gap(gappy));
            end
            drain_steps();
        end

        $display("Ran %0d particle steps and compared %0d results: %0d ended on a cube edge, %0d expired.",
                 sb.accepted, sb.checked, sb.edge_hits, sb.expired_hits);
        $display("Lifetime limit swept over 0, 1, 260, 510, 511 and random values; unmapped write tried.");
        if (sb.errors == 0) begin
            $display("** cube_surface_particle_step: PASSED **");
        end else begin
            $display("** cube_surface_particle_step: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("** cube_surface_particle_step: FAILED **");
        $finish;
    end

endmodule
